>>> rtl/serial_command_stream_parser_macros.svh
// ----------------------------------------------------------------------------
// Serial command stream parser - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_STREAM_PARSER_MACROS_SVH
`define SERIAL_COMMAND_STREAM_PARSER_MACROS_SVH

// expr must hold at every edge out of reset
`define SCSP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("scsp assertion failed");

// same-cycle implication
`define SCSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scsp assertion failed");

// next-cycle implication
`define SCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scsp assertion failed");

`endif

>>> rtl/scsp_pkg.sv
// ----------------------------------------------------------------------------
// Serial command stream parser - package
// Constants, character codes and shared types.
// ----------------------------------------------------------------------------
package scsp_pkg;

    localparam int IP_MAX_CHARS = 15;
    localparam int IP_CNT_W     = $clog2(IP_MAX_CHARS + 1);
    localparam int IP_LEN_W     = 4;
    localparam int CMD_VAL_W    = 16;
    localparam int PIN_W        = 16;

    localparam logic [15:0] PIN_RESET = 16'h7891;

    localparam logic REG_PIN_CODE = 1'b0;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_MUX      = 2'd1;
    localparam logic [1:0] ACT_SERVER   = 2'd2;
    localparam logic [1:0] ACT_COMPLETE = 2'd3;

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;

    typedef logic [IP_CNT_W-1:0] t_ip_cnt;
    typedef logic [IP_LEN_W-1:0] t_ip_len;

    typedef struct packed {
        logic                 done;
        logic [7:0]           letter;
        logic [CMD_VAL_W-1:0] value;
    } t_cmd_result;

    // F B R L W K I E A D S X G
    function automatic logic is_cmd_letter(input logic [7:0] c);
        return c inside {8'h46, 8'h42, 8'h52, 8'h4C, 8'h57, 8'h4B, 8'h49,
                         8'h45, 8'h41, 8'h44, 8'h53, 8'h58, 8'h47};
    endfunction

endpackage

>>> rtl/scsp_cmd_parser.sv
// ----------------------------------------------------------------------------
// Command parser
// Caret, four PIN digits, command letter, decimal value mod 2^16.
// ----------------------------------------------------------------------------
module scsp_cmd_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [7:0]                i_byte,
    input  logic [scsp_pkg::PIN_W-1:0] i_pin_code,
    output scsp_pkg::t_cmd_result     o_result
);

    typedef enum logic [2:0] {
        CMD_HUNT,
        CMD_PIN0,
        CMD_PIN1,
        CMD_PIN2,
        CMD_PIN3,
        CMD_LETTER,
        CMD_VALUE
    } t_cmd_phase;

    t_cmd_phase                      r_phase, n_phase;
    logic [7:0]                      r_letter, n_letter;
    logic [scsp_pkg::CMD_VAL_W-1:0]  r_value, n_value;
    logic [3:0]                      pin_nib;
    logic                            pin_ok;
    logic                            is_digit;
    logic                            is_term;

    always_comb begin
        case (r_phase)
            CMD_PIN0: pin_nib = i_pin_code[15:12];
            CMD_PIN1: pin_nib = i_pin_code[11:8];
            CMD_PIN2: pin_nib = i_pin_code[7:4];
            CMD_PIN3: pin_nib = i_pin_code[3:0];
            default:  pin_nib = 4'h0;
        endcase
    end

    assign pin_ok   = (pin_nib <= 4'd9) && (i_byte == {4'h3, pin_nib});
    assign is_digit = (i_byte >= scsp_pkg::CH_ZERO) && (i_byte <= scsp_pkg::CH_NINE);
    assign is_term  = (i_byte == scsp_pkg::CH_CR) || (i_byte == scsp_pkg::CH_LF) ||
                      (i_byte == scsp_pkg::CH_CARET);

    always_comb begin
        n_phase  = r_phase;
        n_letter = r_letter;
        n_value  = r_value;
        o_result = '0;
        case (r_phase)
            CMD_HUNT: begin
                if (i_byte == scsp_pkg::CH_CARET) n_phase = CMD_PIN0;
            end
            CMD_PIN0: n_phase = pin_ok ? CMD_PIN1   : CMD_HUNT;
            CMD_PIN1: n_phase = pin_ok ? CMD_PIN2   : CMD_HUNT;
            CMD_PIN2: n_phase = pin_ok ? CMD_PIN3   : CMD_HUNT;
            CMD_PIN3: n_phase = pin_ok ? CMD_LETTER : CMD_HUNT;
            CMD_LETTER: begin
                if (scsp_pkg::is_cmd_letter(i_byte)) begin
                    n_letter = i_byte;
                    n_value  = '0;
                    n_phase  = CMD_VALUE;
                end else begin
                    n_phase = CMD_HUNT;
                end
            end
            CMD_VALUE: begin
                if (is_digit) begin
                    // x*10 = x*8 + x*2
                    n_value = (r_value << 3) + (r_value << 1) +
                              {8'h00, i_byte - scsp_pkg::CH_ZERO};
                end else if (is_term) begin
                    o_result.done   = 1'b1;
                    o_result.letter = r_letter;
                    o_result.value  = r_value;
                    // caret terminator opens the next command
                    n_phase = (i_byte == scsp_pkg::CH_CARET) ? CMD_PIN0 : CMD_HUNT;
                end else begin
                    n_phase = CMD_HUNT;
                end
            end
            default: n_phase = CMD_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= CMD_HUNT;
            r_letter <= '0;
            r_value  <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_letter <= n_letter;
            r_value  <= n_value;
        end
    end

endmodule

>>> rtl/serial_command_stream_parser.sv
// ----------------------------------------------------------------------------
// Serial command stream parser - top level
// Address capture, command parser and OK/startup sequencer on one byte stream.
//
//  channel   dir  tdata                       tuser
//  s_axis    in   rx_byte                     kind
//  m_axis    out  ip_char..startup_action     ip_char_valid, ip_done, cmd_done
//  apb       in   pin_code at 0x0             -
//
//  One item per cycle sustained while the output is not stalled. Path: input
//  register, then parse logic into the output register. All three parsers
//  update in the cycle a byte item moves there; a start item only restarts
//  the startup sequence. A stalled output holds; the input register still
//  takes one more item. Synchronous active-low reset returns all parsers to
//  searching and the PIN register to 0x7891.
// ----------------------------------------------------------------------------
module serial_command_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] ip_char, [11:8] ip_length,
                                        // [19:12] cmd_letter, [35:20] cmd_value,
                                        // [37:36] startup_action, [39:38] zero
    output logic [2:0]  m_axis_tuser,   // [0] ip_char_valid, [1] ip_done, [2] cmd_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        IP_HUNT,
        IP_GOT_I,
        IP_GOT_P,
        IP_GOT_COMMA,
        IP_CAPTURE
    } t_ip_phase;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_ONE,
        STEP_TWO,
        STEP_THREE
    } t_step;

    logic                          r_in_vld;
    logic                          r_in_kind;
    logic [7:0]                    r_in_byte;
    logic                          r_out_vld;
    logic [39:0]                   r_out_data;
    logic [2:0]                    r_out_user;
    logic [scsp_pkg::PIN_W-1:0]    r_pin_code;

    t_ip_phase                     r_ip_phase, n_ip_phase;
    scsp_pkg::t_ip_cnt             r_ip_count, n_ip_count;
    logic                          r_o_seen, n_o_seen;
    t_step                         r_step, n_step;

    logic                          advance;
    logic                          byte_en;
    logic                          cfg_wr;
    logic                          ip_char_valid;
    logic [7:0]                    ip_char;
    logic                          ip_done;
    scsp_pkg::t_ip_len             ip_length;
    logic [1:0]                    action;
    scsp_pkg::t_cmd_result         cmd_res;
    logic [39:0]                   n_out_data;
    logic [2:0]                    n_out_user;

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || !r_out_vld || m_axis_tready;
    assign byte_en       = advance && (r_in_kind == scsp_pkg::KIND_BYTE);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == scsp_pkg::REG_PIN_CODE);
    assign prdata = (paddr[2] == scsp_pkg::REG_PIN_CODE) ? {16'h0000, r_pin_code} : 32'h0;

    scsp_cmd_parser u_cmd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (byte_en),
        .i_byte     (r_in_byte),
        .i_pin_code (r_pin_code),
        .o_result   (cmd_res)
    );

    // address parser
    always_comb begin
        n_ip_phase    = IP_HUNT;
        n_ip_count    = r_ip_count;
        ip_char_valid = 1'b0;
        ip_char       = 8'h00;
        ip_done       = 1'b0;
        ip_length     = '0;
        case (r_ip_phase)
            IP_HUNT: begin
                if (r_in_byte == scsp_pkg::CH_I) n_ip_phase = IP_GOT_I;
            end
            IP_GOT_I: begin
                if (r_in_byte == scsp_pkg::CH_P) n_ip_phase = IP_GOT_P;
            end
            IP_GOT_P: begin
                if (r_in_byte == scsp_pkg::CH_COMMA) n_ip_phase = IP_GOT_COMMA;
            end
            IP_GOT_COMMA: begin
                if (r_in_byte == scsp_pkg::CH_QUOTE) begin
                    n_ip_phase = IP_CAPTURE;
                    n_ip_count = '0;
                end
            end
            IP_CAPTURE: begin
                n_ip_phase = IP_CAPTURE;
                if (r_in_byte == scsp_pkg::CH_QUOTE) begin
                    ip_done    = 1'b1;
                    ip_length  = scsp_pkg::t_ip_len'(r_ip_count);
                    n_ip_phase = IP_HUNT;
                end else if (r_ip_count < scsp_pkg::IP_CNT_W'(scsp_pkg::IP_MAX_CHARS)) begin
                    ip_char_valid = 1'b1;
                    ip_char       = r_in_byte;
                    n_ip_count    = r_ip_count + 1'b1;
                end
            end
            default: n_ip_phase = IP_HUNT;
        endcase
    end

    // OK detector and startup sequence
    always_comb begin
        n_o_seen = r_o_seen;
        n_step   = r_step;
        action   = scsp_pkg::ACT_NONE;
        if (!r_o_seen && r_in_byte == scsp_pkg::CH_O) begin
            n_o_seen = 1'b1;
        end else if (r_o_seen && r_in_byte == scsp_pkg::CH_K) begin
            n_o_seen = 1'b0;
            case (r_step)
                STEP_ONE: begin
                    action = scsp_pkg::ACT_MUX;
                    n_step = STEP_TWO;
                end
                STEP_TWO: begin
                    action = scsp_pkg::ACT_SERVER;
                    n_step = STEP_THREE;
                end
                STEP_THREE: begin
                    action = scsp_pkg::ACT_COMPLETE;
                    n_step = STEP_IDLE;
                end
                default: n_step = r_step;
            endcase
        end else if (r_in_byte != scsp_pkg::CH_O) begin
            n_o_seen = 1'b0;
        end
    end

    always_comb begin
        if (r_in_kind == scsp_pkg::KIND_START) begin
            n_out_data = '0;
            n_out_user = '0;
        end else begin
            n_out_data = {2'b00, action, cmd_res.value, cmd_res.letter, ip_length, ip_char};
            n_out_user = {cmd_res.done, ip_done, ip_char_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pin_code <= scsp_pkg::PIN_RESET;
            r_ip_phase <= IP_HUNT;
            r_ip_count <= '0;
            r_o_seen   <= 1'b0;
            r_step     <= STEP_IDLE;
        end else begin
            if (cfg_wr) r_pin_code <= pwdata[15:0];

            if (s_axis_tvalid && s_axis_tready) r_in_vld <= 1'b1;
            else if (advance)                   r_in_vld <= 1'b0;

            if (advance)            r_out_vld <= 1'b1;
            else if (m_axis_tready) r_out_vld <= 1'b0;

            if (advance) begin
                if (r_in_kind == scsp_pkg::KIND_START) begin
                    r_step <= STEP_ONE;
                end else begin
                    r_ip_phase <= n_ip_phase;
                    r_ip_count <= n_ip_count;
                    r_o_seen   <= n_o_seen;
                    r_step     <= n_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
        if (advance) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

>>> rtl/scsp_checker.sv
// ----------------------------------------------------------------------------
// Serial command stream parser - port checker
// Assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_command_stream_parser_macros.svh"

module scsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        pready
);

    // stalled item holds
    `SCSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a closing quote is never also a captured character
    `SCSP_ASSERT_IMPLY(a_ip_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

    // length and command fields are zero unless their flag is set
    `SCSP_ASSERT_IMPLY(a_ip_len_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[11:8] == 4'h0)
    `SCSP_ASSERT_IMPLY(a_cmd_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[35:12] == 24'h0)

    `SCSP_ASSERT_ALWAYS(a_pready, i_clk, i_rst_n, pready)

endmodule

bind serial_command_stream_parser scsp_checker u_scsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);

>>> tb/sv/serial_command_stream_parser_checker.sv
// ----------------------------------------------------------------------------
// Serial command stream parser - result checker
// Watches the input, output and register channels. For each accepted input
// item it predicts the address, command and startup results, queues them and
// compares every accepted output item against the oldest one field by field.
// ----------------------------------------------------------------------------
module serial_command_stream_parser_checker
    import scsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [7:0]  i_in_tdata,
    input  logic [0:0]  i_in_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [39:0] i_out_tdata,
    input  logic [2:0]  i_out_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] PIN_ADDR = 3'(4 * REG_PIN_CODE);

    typedef enum logic [2:0] {
        IP_HUNT_I, IP_HUNT_P, IP_HUNT_COMMA, IP_HUNT_QUOTE, IP_CAPTURE
    } addr_phase_t;

    typedef enum logic [2:0] {
        CMD_HUNT, CMD_PIN0, CMD_PIN1, CMD_PIN2, CMD_PIN3, CMD_LETTER, CMD_VALUE
    } cmd_phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE, SEQ_WAIT_MUX, SEQ_WAIT_SERVER, SEQ_WAIT_DONE
    } seq_step_t;

    typedef struct packed {
        logic        ip_char_valid;
        logic [7:0]  ip_char;
        logic        ip_done;
        logic [3:0]  ip_length;
        logic        cmd_done;
        logic [7:0]  cmd_letter;
        logic [15:0] cmd_value;
        logic [1:0]  startup_action;
    } parse_result_t;

    logic [15:0]   pin_code;
    addr_phase_t   addr_phase;
    int            addr_count;
    cmd_phase_t    cmd_phase;
    logic [7:0]    held_letter;
    logic [15:0]   accum;
    logic          o_pending;
    seq_step_t     seq_step;

    parse_result_t result_q[$];
    parse_result_t want;
    parse_result_t got;
    int            fail_count;

    assign o_fail_count  = fail_count;

    initial fail_count = 0;

    function automatic logic letter_is_command(input logic [7:0] c);
        case (c)
            "F", "B", "R", "L", "W", "K", "I", "E", "A", "D", "S", "X", "G": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic parse_result_t parse_item(input logic kind, input logic [7:0] c);
        parse_result_t r;
        int            pos;
        logic [3:0]    nib;
        r = '0;
        if (kind == KIND_START) begin
            seq_step = SEQ_WAIT_MUX;
            return r;
        end

        if (addr_phase == IP_HUNT_I && c == CH_I) addr_phase = IP_HUNT_P;
        else if (addr_phase == IP_HUNT_P && c == CH_P) addr_phase = IP_HUNT_COMMA;
        else if (addr_phase == IP_HUNT_COMMA && c == CH_COMMA) addr_phase = IP_HUNT_QUOTE;
        else if (addr_phase == IP_HUNT_QUOTE && c == CH_QUOTE) begin
            addr_phase = IP_CAPTURE;
            addr_count = 0;
        end else if (addr_phase == IP_CAPTURE) begin
            if (c == CH_QUOTE) begin
                r.ip_done   = 1'b1;
                r.ip_length = 4'(addr_count);
                addr_phase  = IP_HUNT_I;
            end else if (addr_count < IP_MAX_CHARS) begin
                r.ip_char_valid = 1'b1;
                r.ip_char       = c;
                addr_count++;
            end
        end else begin
            addr_phase = IP_HUNT_I;
        end

        case (cmd_phase)
            CMD_HUNT: begin
                if (c == CH_CARET) cmd_phase = CMD_PIN0;
            end
            CMD_PIN0, CMD_PIN1, CMD_PIN2, CMD_PIN3: begin
                pos = int'(cmd_phase - CMD_PIN0);
                nib = pin_code[(3 - pos) * 4 +: 4];
                if (nib <= 4'd9 && c == CH_ZERO + nib) cmd_phase = cmd_phase_t'(cmd_phase + 1);
                else cmd_phase = CMD_HUNT;
            end
            CMD_LETTER: begin
                if (letter_is_command(c)) begin
                    held_letter = c;
                    accum       = '0;
                    cmd_phase   = CMD_VALUE;
                end else begin
                    cmd_phase = CMD_HUNT;
                end
            end
            CMD_VALUE: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    accum = 16'(accum * 10 + (c - CH_ZERO));
                end else if (c == CH_CR || c == CH_LF || c == CH_CARET) begin
                    r.cmd_done   = 1'b1;
                    r.cmd_letter = held_letter;
                    r.cmd_value  = accum;
                    cmd_phase    = (c == CH_CARET) ? CMD_PIN0 : CMD_HUNT;
                end else begin
                    cmd_phase = CMD_HUNT;
                end
            end
            default: cmd_phase = CMD_HUNT;
        endcase

        if (!o_pending && c == CH_O) begin
            o_pending = 1'b1;
        end else if (o_pending && c == CH_K) begin
            o_pending = 1'b0;
            case (seq_step)
                SEQ_WAIT_MUX: begin
                    r.startup_action = ACT_MUX;
                    seq_step = SEQ_WAIT_SERVER;
                end
                SEQ_WAIT_SERVER: begin
                    r.startup_action = ACT_SERVER;
                    seq_step = SEQ_WAIT_DONE;
                end
                SEQ_WAIT_DONE: begin
                    r.startup_action = ACT_COMPLETE;
                    seq_step = SEQ_IDLE;
                end
                default: ;
            endcase
        end else if (c != CH_O) begin
            o_pending = 1'b0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pin_code    = PIN_RESET;
            addr_phase  = IP_HUNT_I;
            addr_count  = 0;
            cmd_phase   = CMD_HUNT;
            held_letter = '0;
            accum       = '0;
            o_pending   = 1'b0;
            seq_step    = SEQ_IDLE;
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == PIN_ADDR)
                pin_code = i_pwdata[15:0];
            if (i_in_tvalid && i_in_tready)
                result_q.push_back(parse_item(i_in_tuser[0], i_in_tdata));
            if (i_out_tvalid && i_out_tready) begin
                got.ip_char_valid  = i_out_tuser[0];
                got.ip_done        = i_out_tuser[1];
                got.cmd_done       = i_out_tuser[2];
                got.ip_char        = i_out_tdata[7:0];
                got.ip_length      = i_out_tdata[11:8];
                got.cmd_letter     = i_out_tdata[19:12];
                got.cmd_value      = i_out_tdata[35:20];
                got.startup_action = i_out_tdata[37:36];
                if (result_q.size() == 0) begin
                    $error("output item with no result expected");
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("ip_char_valid", 16'(want.ip_char_valid), 16'(got.ip_char_valid));
                    check_field("ip_char", 16'(want.ip_char), 16'(got.ip_char));
                    check_field("ip_done", 16'(want.ip_done), 16'(got.ip_done));
                    check_field("ip_length", 16'(want.ip_length), 16'(got.ip_length));
                    check_field("cmd_done", 16'(want.cmd_done), 16'(got.cmd_done));
                    check_field("cmd_letter", 16'(want.cmd_letter), 16'(got.cmd_letter));
                    check_field("cmd_value", want.cmd_value, got.cmd_value);
                    check_field("startup_action", 16'(want.startup_action),
                                16'(got.startup_action));
                    check_field("tdata pad", 16'h0, 16'(i_out_tdata[39:38]));
                end
            end
        end
        o_outstanding = result_q.size();
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Serial command stream parser - testbench top
// Drives directed and random byte streams (address headers, PIN commands,
// OK startup sequences, noise) under several PIN settings with random gaps
// and output stalls; the checker module predicts and compares all results.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scsp_pkg::*;

    localparam logic [2:0] PIN_ADDR = 3'(4 * REG_PIN_CODE);
    localparam int HOLD_CYCLES = 120;

    typedef struct {
        logic       kind;
        logic [7:0] rx;
    } rx_item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          outstanding;

    rx_item_t    to_send[$];
    logic [15:0] pin_now = PIN_RESET;
    bit          calm = 1'b0;
    int          hold_asked = 0;
    int          hold_taken = 0;
    int          hold_left = 0;

    always #5 i_clk = ~i_clk;

    serial_command_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    serial_command_stream_parser_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_out_tuser   (m_axis_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // output side: random stalls, plus one long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_taken != hold_asked) begin
                hold_taken++;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    task automatic push_byte(input logic kind, input logic [7:0] b);
        rx_item_t it;
        it.kind = kind;
        it.rx   = b;
        to_send.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(KIND_BYTE, s[i]);
    endtask

    task automatic gen_traffic(input int n);
        int         target;
        logic [7:0] b;
        bit         chained;
        string      letters;
        letters = "FBRLWKIEADSXG";
        target  = to_send.size() + n;
        chained = 1'b0;
        while (to_send.size() < target) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    if (!chained) push_byte(KIND_BYTE, CH_CARET);
                    for (int d = 0; d < 4; d++) begin
                        if ($urandom_range(19) == 0)
                            push_byte(KIND_BYTE, 8'($urandom_range(CH_ZERO, CH_NINE)));
                        else
                            push_byte(KIND_BYTE, 8'(CH_ZERO + pin_now[(3 - d) * 4 +: 4]));
                    end
                    if ($urandom_range(14) == 0) push_byte(KIND_BYTE, 8'($urandom));
                    else push_byte(KIND_BYTE, letters[$urandom_range(12)]);
                    repeat ($urandom_range(7)) begin
                        if ($urandom_range(3) == 0) push_byte(KIND_BYTE, "9");
                        else push_byte(KIND_BYTE, 8'($urandom_range(CH_ZERO, CH_NINE)));
                    end
                    case ($urandom_range(7))
                        0, 1:    b = CH_CR;
                        2, 3:    b = CH_LF;
                        4, 5, 6: b = CH_CARET;
                        default: b = 8'($urandom);
                    endcase
                    push_byte(KIND_BYTE, b);
                    chained = (b == CH_CARET);
                end
                4, 5: begin
                    chained = 1'b0;
                    case ($urandom_range(9))
                        0:       push_text("IIP,\"");
                        1:       push_text("IP\"");
                        default: push_text("IP,\"");
                    endcase
                    repeat ($urandom_range(20)) begin
                        b = 8'($urandom);
                        if (b == CH_QUOTE) b = ".";
                        push_byte(KIND_BYTE, b);
                    end
                    push_byte(KIND_BYTE, CH_QUOTE);
                end
                6: begin
                    chained = 1'b0;
                    push_byte(KIND_START, 8'($urandom));
                    repeat (3) begin
                        if ($urandom_range(3) == 0) push_byte(KIND_BYTE, 8'($urandom));
                        if ($urandom_range(2) == 0) push_text("OOK");
                        else push_text("OK");
                    end
                end
                default: begin
                    chained = 1'b0;
                    repeat ($urandom_range(1, 4))
                        push_byte(($urandom_range(15) == 0) ? KIND_START : KIND_BYTE,
                                  8'($urandom));
                end
            endcase
        end
    endtask

    task automatic send_all();
        bit done;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            if (s_axis_tvalid && s_axis_tready) void'(to_send.pop_front());
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the offered item
            end else if (to_send.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                done = 1'b1;
            end else if (!calm && $urandom_range(99) < 12) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= to_send[0].rx;
                s_axis_tuser  <= to_send[0].kind;
            end
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_pin(input logic [15:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PIN_ADDR;
        pwdata  <= {16'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pin_now = v;
    endtask

    initial begin
        logic [15:0] pin_plan[5];
        int          count_plan[5];
        pin_plan   = '{16'h0000, 16'h9999, 16'hFFFF, 16'h0000, PIN_RESET};
        count_plan = '{70, 70, 40, 70, 50};
        pin_plan[3] = {4'($urandom_range(9)), 4'($urandom_range(9)),
                       4'($urandom_range(9)), 4'($urandom_range(9))};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(KIND_START, 8'hFF);
        push_text("OOK");
        push_text("IP,\"1\"");
        push_text("^7891W70000^");
        push_text("7891K");
        push_byte(KIND_BYTE, CH_LF);
        gen_traffic(100);
        send_all();
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            write_pin(pin_plan[p]);
            calm = (p == 1);
            if (p == 0) hold_asked++;
            gen_traffic(count_plan[p]);
            send_all();
            wait_idle();
        end
        calm = 1'b0;

        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/scsp_pkg.sv
rtl/scsp_cmd_parser.sv
rtl/serial_command_stream_parser.sv
rtl/scsp_checker.sv
tb/sv/serial_command_stream_parser_checker.sv
tb/sv/tb.sv
